### hdl/edps_pkg.sv
// ----------------------------------------------------------------------------
// Echo distance PD steering package
// Shared types, widths and constants for the steering unit and its parts.
// ----------------------------------------------------------------------------
package edps_pkg;

    // Input and result field widths.
    localparam int TICKS_W  = 16;
    localparam int DUTY_W   = 8;
    localparam int WHOLE_W  = 10;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 3;

    // The distance is floor(ticks * 256 / 116) = floor(ticks * 64 / 29).
    // It is formed as (ticks * RECIP) >> RECIP_SHIFT with RECIP = ceil(2^27 / 29).
    // The reciprocal error (14 / 2^27 per unit) times the largest dividend
    // stays below one, so the quotient is exact for every 16-bit tick count.
    localparam int RECIP_W     = 23;
    localparam logic [RECIP_W-1:0] RECIP = 23'd4628198;
    localparam int PROD_W      = TICKS_W + RECIP_W;
    localparam int RECIP_SHIFT = 21;
    localparam int DIST_W      = PROD_W - RECIP_SHIFT;

    // Signed widths along the correction path (Q8 errors, Q16 products).
    localparam int ERR_W   = 19;
    localparam int DERIV_W = 20;
    localparam int P_W     = CFG_W + 1 + ERR_W;
    localparam int D_W     = CFG_W + 1 + DERIV_W;
    localparam int CORR_W  = D_W + 1;
    localparam int SUM_W   = CORR_W + 1;

    // Decoupling queue between the front and the back.
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET    = 3'd0,
        REG_PROP_GAIN = 3'd1,
        REG_DERIV_GAIN = 3'd2,
        REG_LEFT_MIN  = 3'd3,
        REG_LEFT_MAX  = 3'd4,
        REG_RIGHT_MIN = 3'd5,
        REG_RIGHT_MAX = 3'd6
    } reg_idx_t;

    // Configuration register file contents.
    typedef struct packed {
        logic [CFG_W-1:0]  target;
        logic [CFG_W-1:0]  prop_gain;
        logic [CFG_W-1:0]  deriv_gain;
        logic [DUTY_W-1:0] left_min;
        logic [DUTY_W-1:0] left_max;
        logic [DUTY_W-1:0] right_min;
        logic [DUTY_W-1:0] right_max;
    } cfg_t;

    // One queued transaction: the Q16 correction and the whole centimetres.
    typedef struct packed {
        logic signed [CORR_W-1:0] corr;
        logic [WHOLE_W-1:0]       whole_cm;
    } q_entry_t;

    // Front-to-queue control.
    typedef struct packed {
        logic push;
        logic full;
    } q_ctrl_t;

    // Clamp a Q16 speed sum to [lo, hi] and floor it to an integer duty.
    // A value below lo gives lo; otherwise a value above hi gives hi.
    function automatic logic [DUTY_W-1:0] clamp_floor(
        input logic signed [SUM_W-1:0] value,
        input logic [DUTY_W-1:0]       lo,
        input logic [DUTY_W-1:0]       hi
    );
        logic signed [SUM_W-1:0] lo_q;
        logic signed [SUM_W-1:0] hi_q;
        lo_q = $signed({{(SUM_W - DUTY_W - 16){1'b0}}, lo, 16'h0000});
        hi_q = $signed({{(SUM_W - DUTY_W - 16){1'b0}}, hi, 16'h0000});
        if (value < lo_q)
        begin
            return lo;
        end
        else if (value > hi_q)
        begin
            return hi;
        end
        else
        begin
            return value[16 +: DUTY_W];
        end
    endfunction

endpackage

### hdl/edps_front.sv
// ----------------------------------------------------------------------------
// Steering front end
// Accepts echo widths, converts them to distance, forms the error and
// derivative and the PD correction, and pushes the result into the queue.
// ----------------------------------------------------------------------------
module edps_front
    import edps_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [TICKS_W-1:0]        echo_ticks,
    input  cfg_t                      cfg,
    input  logic                      q_full,
    output logic                      q_push,
    output q_entry_t                  q_data
);

    logic                       v1_reg;
    logic                       v2_reg;
    logic                       v3_reg;
    logic [PROD_W-1:0]          prod_reg;
    logic signed [ERR_W-1:0]    err_reg;
    logic signed [DERIV_W-1:0]  deriv_reg;
    logic signed [ERR_W-1:0]    prev_err_reg;
    logic signed [ERR_W-1:0]    prev_err_next;
    logic [WHOLE_W-1:0]         whole2_reg;
    logic [WHOLE_W-1:0]         whole3_reg;
    logic signed [P_W-1:0]      p_reg;
    logic signed [D_W-1:0]      d_reg;
    logic                       en;
    logic [DIST_W-1:0]          dist_q8;
    logic signed [ERR_W-1:0]    err_w;
    logic signed [DERIV_W-1:0]  deriv_w;

    // The whole pipeline moves together; it holds only when the last stage
    // has a transaction that the queue cannot take.
    assign en       = !v3_reg || !q_full;
    assign in_stall = !en;
    assign q_push   = v3_reg && !q_full;

    // Stage one result: distance in Q8 centimetres, then error and derivative.
    assign dist_q8 = prod_reg[RECIP_SHIFT +: DIST_W];
    assign err_w   = $signed({{(ERR_W - CFG_W){1'b0}}, cfg.target})
                   - $signed({{(ERR_W - DIST_W){1'b0}}, dist_q8});
    assign deriv_w = $signed({err_w[ERR_W-1], err_w})
                   - $signed({prev_err_reg[ERR_W-1], prev_err_reg});
    assign prev_err_next = v1_reg ? err_w : prev_err_reg;

    // Last stage sums the two products into the correction.
    assign q_data.corr = $signed({{(CORR_W - P_W){p_reg[P_W-1]}}, p_reg})
                       + $signed({{(CORR_W - D_W){d_reg[D_W-1]}}, d_reg});
    assign q_data.whole_cm = whole3_reg;

    // Valid bits and the stored previous error.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            prev_err_reg <= '0;
        end
        else if (en)
        begin
            v1_reg       <= in_valid;
            v2_reg       <= v1_reg;
            v3_reg       <= v2_reg;
            prev_err_reg <= prev_err_next;
        end
    end

    // Payload stages: reciprocal multiply, subtraction, gain multiplies.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg   <= echo_ticks * RECIP;
            err_reg    <= err_w;
            deriv_reg  <= deriv_w;
            whole2_reg <= dist_q8[DIST_W-1 -: WHOLE_W];
            p_reg      <= $signed({1'b0, cfg.prop_gain}) * err_reg;
            d_reg      <= $signed({1'b0, cfg.deriv_gain}) * deriv_reg;
            whole3_reg <= whole2_reg;
        end
    end

    // An accepted transaction always lands in the first stage.
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> v1_reg)
        else $error("accepted transaction did not enter the first stage");

endmodule

### hdl/edps_queue.sv
// ----------------------------------------------------------------------------
// Steering decoupling queue
// Short FIFO that lets the front end and the back end stall independently.
// ----------------------------------------------------------------------------
module edps_queue
    import edps_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  q_ctrl_t  ctrl,
    input  q_entry_t wr_data,
    input  logic     pop,
    output logic     not_empty,
    output logic     full,
    output q_entry_t rd_data
);

    q_entry_t          store [Q_DEPTH];
    logic [Q_AW-1:0]   wr_ptr_reg;
    logic [Q_AW-1:0]   rd_ptr_reg;
    logic [Q_CW-1:0]   count_reg;
    logic [Q_CW-1:0]   count_next;

    assign not_empty = (count_reg != '0);
    assign rd_data   = store[rd_ptr_reg];

    // Full when occupancy reaches the depth.
    assign full = (count_reg == Q_CW'(Q_DEPTH));

    // Occupancy follows pushes and pops.
    always_comb
    begin
        count_next = count_reg;
        if (ctrl.push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!ctrl.push && pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers and count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (ctrl.push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            store[wr_ptr_reg] <= wr_data;
        end
    end

    // Full flag as seen by the front end.
    assign_full_check: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.full == (count_reg == Q_CW'(Q_DEPTH)))
        else $error("queue full flag disagrees with occupancy");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.push |-> (count_reg != Q_CW'(Q_DEPTH)))
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("pop from an empty queue");

endmodule

### hdl/edps_back.sv
// ----------------------------------------------------------------------------
// Steering back end
// Applies the queued correction to both motor speeds, clamps them and holds
// the result transaction in the output register.
// ----------------------------------------------------------------------------
module edps_back
    import edps_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cfg_t                 cfg,
    input  logic                 q_valid,
    input  q_entry_t             q_data,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [DUTY_W-1:0]    left_duty,
    output logic [DUTY_W-1:0]    right_duty,
    output logic [WHOLE_W-1:0]   distance_whole_cm
);

    logic                     out_valid_reg;
    logic [DUTY_W-1:0]        left_speed_reg;
    logic [DUTY_W-1:0]        right_speed_reg;
    logic [DUTY_W-1:0]        left_speed_next;
    logic [DUTY_W-1:0]        right_speed_next;
    logic [WHOLE_W-1:0]       whole_reg;
    logic                     out_ready;
    logic signed [SUM_W-1:0]  corr_ext;
    logic signed [SUM_W-1:0]  left_sum;
    logic signed [SUM_W-1:0]  right_sum;

    // The output register is free when empty or being taken.
    assign out_ready = !out_valid_reg || !out_stall;
    assign pop       = q_valid && out_ready;

    // Speed update: left adds the correction, right subtracts it.
    assign corr_ext  = $signed({q_data.corr[CORR_W-1], q_data.corr});
    assign left_sum  = $signed({{(SUM_W - DUTY_W - 16){1'b0}}, left_speed_reg, 16'h0000})
                     + corr_ext;
    assign right_sum = $signed({{(SUM_W - DUTY_W - 16){1'b0}}, right_speed_reg, 16'h0000})
                     - corr_ext;
    assign left_speed_next  = clamp_floor(left_sum, cfg.left_min, cfg.left_max);
    assign right_speed_next = clamp_floor(right_sum, cfg.right_min, cfg.right_max);

    // The speed state doubles as the duty output.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            left_speed_reg  <= '0;
            right_speed_reg <= '0;
        end
        else
        begin
            if (out_ready)
            begin
                out_valid_reg <= q_valid;
            end
            if (pop)
            begin
                left_speed_reg  <= left_speed_next;
                right_speed_reg <= right_speed_next;
            end
        end
    end

    // Distance payload of the result transaction.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            whole_reg <= q_data.whole_cm;
        end
    end

    assign out_valid         = out_valid_reg;
    assign left_duty         = left_speed_reg;
    assign right_duty        = right_speed_reg;
    assign distance_whole_cm = whole_reg;

    // Every popped entry becomes a visible result transaction.
    a_pop_shows: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> out_valid_reg)
        else $error("popped entry did not reach the output register");

endmodule

### hdl/echo_distance_pd_steer_unit.sv
// ----------------------------------------------------------------------------
// Echo distance PD steering unit
// Top level: configuration registers, front end, queue and back end.
// ----------------------------------------------------------------------------
// Each echo width transaction yields one result transaction with both motor
// duties and the whole-centimetre distance. The unit takes one transaction
// per clock cycle when the output is not stalled; a result passes through three
// front-end stages (the reciprocal multiply, the error subtraction and the
// gain multiplies), then the queue and then the output register. The
// per-cycle rate is set by the speed update in the back end, a single add and
// clamp per transaction. A four-entry queue absorbs output stalls before the
// input stalls. Configuration registers may only be written while the unit
// is idle.
// ----------------------------------------------------------------------------
module echo_distance_pd_steer_unit
    import edps_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [TICKS_W-1:0]    echo_ticks,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [DUTY_W-1:0]     left_duty,
    output logic [DUTY_W-1:0]     right_duty,
    output logic [WHOLE_W-1:0]    distance_whole_cm,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

    cfg_t      cfg_reg;
    q_ctrl_t   q_ctrl;
    q_entry_t  q_wr_data;
    q_entry_t  q_rd_data;
    logic      q_not_empty;
    logic      q_pop;
    logic      q_push;
    logic      q_full;

    // Configuration register file; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target     <= 16'd10240;
            cfg_reg.prop_gain  <= 16'd1280;
            cfg_reg.deriv_gain <= 16'd51;
            cfg_reg.left_min   <= 8'd80;
            cfg_reg.left_max   <= 8'd150;
            cfg_reg.right_min  <= 8'd60;
            cfg_reg.right_max  <= 8'd120;
        end
        else if (cfg_wr_en)
        begin
            case (reg_idx_t'(cfg_index))
                REG_TARGET:     cfg_reg.target     <= cfg_data;
                REG_PROP_GAIN:  cfg_reg.prop_gain  <= cfg_data;
                REG_DERIV_GAIN: cfg_reg.deriv_gain <= cfg_data;
                REG_LEFT_MIN:   cfg_reg.left_min   <= cfg_data[DUTY_W-1:0];
                REG_LEFT_MAX:   cfg_reg.left_max   <= cfg_data[DUTY_W-1:0];
                REG_RIGHT_MIN:  cfg_reg.right_min  <= cfg_data[DUTY_W-1:0];
                REG_RIGHT_MAX:  cfg_reg.right_max  <= cfg_data[DUTY_W-1:0];
                default: ;
            endcase
        end
    end

    // Queue control bundle.
    assign q_ctrl = '{push: q_push, full: q_full};

    // Front end: distance, error, derivative and correction.
    edps_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .echo_ticks (echo_ticks),
        .cfg        (cfg_reg),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (q_wr_data)
    );

    // Decoupling queue; it also reports when it is full.
    edps_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (q_ctrl),
        .wr_data   (q_wr_data),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .full      (q_full),
        .rd_data   (q_rd_data)
    );

    // Back end: speed update, clamping and output register.
    edps_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg               (cfg_reg),
        .q_valid           (q_not_empty),
        .q_data            (q_rd_data),
        .pop               (q_pop),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .left_duty         (left_duty),
        .right_duty        (right_duty),
        .distance_whole_cm (distance_whole_cm)
    );

endmodule
